// ----- hdl/srw_pkg.sv -----
// shared types and constants for the sequence replay window
// transaction payload structs, command and status codes; no dependencies
package srw_pkg;

   localparam int unsigned SEQ_WIDTH     = 64;
   localparam int unsigned WIN_BITS      = 64;
   localparam int unsigned WIN_IDX_WIDTH = $clog2(WIN_BITS);
   localparam int unsigned WIRE_WIDTH    = 16;
   localparam int unsigned SUMMARY_WIDTH = 16;
   localparam int unsigned SUMMARY_LOW   = 48;

   localparam logic [SEQ_WIDTH-1:0] WIRE_BACKOFF  = SEQ_WIDTH'(1) << 14;
   localparam logic [SEQ_WIDTH-1:0] WIN_SPAN      = SEQ_WIDTH'(WIN_BITS);
   localparam logic [SEQ_WIDTH-1:0] TOP_BIT       = SEQ_WIDTH'(1) << (SEQ_WIDTH - 1);
   localparam logic [SEQ_WIDTH-1:0] BITMAP_RESET  = '1;

   localparam logic [1:0] CMD_CHECK  = 2'd0;
   localparam logic [1:0] CMD_RECORD = 2'd1;
   localparam logic [1:0] CMD_RELOAD = 2'd2;

   typedef enum logic [2:0] {
      STATUS_ADVANCE  = 3'd0,
      STATUS_JUMP     = 3'd1,
      STATUS_FILL     = 3'd2,
      STATUS_DUP      = 3'd3,
      STATUS_OLD      = 3'd4,
      STATUS_RELOADED = 3'd5
   } status_type;

   typedef struct packed {
      logic [1:0]           command;
      logic [SEQ_WIDTH-1:0] seq_value;
      logic                 wire_mode;
   } req_type;

   typedef struct packed {
      logic                     accept;
      logic [2:0]               status;
      logic [SEQ_WIDTH-1:0]     full_seq;
      logic [SEQ_WIDTH-1:0]     ack_head;
      logic [SUMMARY_WIDTH-1:0] ack_summary;
   } rsp_type;

   typedef struct packed {
      logic [SEQ_WIDTH-1:0] head_seq;
      logic [SEQ_WIDTH-1:0] recv_bitmap;
   } window_type;

endpackage

// ----- hdl/srw_classify.sv -----
// sequence number rebuild, window classification and next window state
// purely combinational; depends on srw_pkg
module srw_classify (
   input  srw_pkg::req_type    req,
   input  srw_pkg::window_type win,
   output srw_pkg::window_type win_next,
   output srw_pkg::rsp_type    rsp
);

   logic [srw_pkg::SEQ_WIDTH-1:0]            base;
   logic                                     wire_carry;
   logic [srw_pkg::SEQ_WIDTH-1:0]            full_seq;
   logic [srw_pkg::SEQ_WIDTH-1:0]            diff;
   logic [srw_pkg::SEQ_WIDTH-1:0]            diff_m64;
   logic [srw_pkg::SEQ_WIDTH-1:0]            diff_p64;
   logic                                     diff_pos;
   logic                                     in_reach;
   logic                                     too_old;
   logic [srw_pkg::WIN_IDX_WIDTH-1:0]        bit_pos;
   logic                                     bit_seen;
   srw_pkg::status_type                      check_status;
   srw_pkg::status_type                      status;
   logic                                     accept;
   logic [srw_pkg::SEQ_WIDTH-1:0]            bm_next;
   logic [srw_pkg::SEQ_WIDTH-1:0]            head_next;

   always_comb begin
      // wire mode: low bits come from the wire, high part from head minus backoff
      base       = win.head_seq - srw_pkg::WIRE_BACKOFF;
      wire_carry = req.seq_value[srw_pkg::WIRE_WIDTH-1:0] < base[srw_pkg::WIRE_WIDTH-1:0];
      if (req.wire_mode) begin
         full_seq = {base[srw_pkg::SEQ_WIDTH-1:srw_pkg::WIRE_WIDTH]
                        + (srw_pkg::SEQ_WIDTH - srw_pkg::WIRE_WIDTH)'(wire_carry),
                     req.seq_value[srw_pkg::WIRE_WIDTH-1:0]};
      end else begin
         full_seq = req.seq_value;
      end

      diff     = full_seq - win.head_seq;
      diff_m64 = diff - srw_pkg::WIN_SPAN;
      diff_p64 = diff + srw_pkg::WIN_SPAN;
      diff_pos = (diff != '0) && !diff[srw_pkg::SEQ_WIDTH-1];
      in_reach = diff_m64[srw_pkg::SEQ_WIDTH-1];
      too_old  = !((diff_p64 != '0) && !diff_p64[srw_pkg::SEQ_WIDTH-1]);
      bit_pos  = diff[srw_pkg::WIN_IDX_WIDTH-1:0] - srw_pkg::WIN_IDX_WIDTH'(1);
      bit_seen = win.recv_bitmap[bit_pos];

      if (diff_pos) begin
         check_status = in_reach ? srw_pkg::STATUS_ADVANCE : srw_pkg::STATUS_JUMP;
      end else if (too_old) begin
         check_status = srw_pkg::STATUS_OLD;
      end else begin
         check_status = bit_seen ? srw_pkg::STATUS_DUP : srw_pkg::STATUS_FILL;
      end

      head_next = win.head_seq;
      bm_next   = win.recv_bitmap;
      status    = check_status;
      accept    = (check_status == srw_pkg::STATUS_ADVANCE) ||
                  (check_status == srw_pkg::STATUS_JUMP) ||
                  (check_status == srw_pkg::STATUS_FILL);

      unique case (req.command)
         srw_pkg::CMD_RELOAD: begin
            head_next = full_seq;
            bm_next   = srw_pkg::BITMAP_RESET;
            status    = srw_pkg::STATUS_RELOADED;
            accept    = 1'b1;
         end
         srw_pkg::CMD_RECORD: begin
            if (!in_reach) begin
               head_next = full_seq;
               bm_next   = srw_pkg::TOP_BIT;
               status    = srw_pkg::STATUS_JUMP;
               accept    = 1'b1;
            end else if (check_status == srw_pkg::STATUS_ADVANCE) begin
               head_next = full_seq;
               bm_next   = (win.recv_bitmap >> diff[srw_pkg::WIN_IDX_WIDTH-1:0])
                           | srw_pkg::TOP_BIT;
            end else if (check_status == srw_pkg::STATUS_FILL) begin
               bm_next[bit_pos] = 1'b1;
            end
         end
         default: begin
         end
      endcase

      win_next.head_seq    = head_next;
      win_next.recv_bitmap = bm_next;

      rsp.accept      = accept;
      rsp.status      = status;
      rsp.full_seq    = full_seq;
      rsp.ack_head    = head_next;
      rsp.ack_summary = {&bm_next[srw_pkg::SUMMARY_LOW-1:0],
                         bm_next[srw_pkg::SEQ_WIDTH-2:srw_pkg::SUMMARY_LOW]};
   end

endmodule

// ----- hdl/sequence_replay_window_core.sv -----
// top level of the sequence replay window: request register, window state, result register
// depends on srw_pkg and srw_classify
//
// Receive-side anti-replay window over 64-bit sequence numbers. Each request transaction
// (check, record or reload, optionally with a 16-bit wire value rebuilt against the head)
// yields exactly one response transaction with the accept decision, status, rebuilt
// number, head and 16-bit ack summary. A transaction is held in the request register
// and classified combinationally against the window state, which is updated in that
// same cycle; one transaction per clock is sustained while rsp_ready is high. The
// response register lets a new request enter while a finished response still waits;
// reset restores head 0 and an all-ones window.
module sequence_replay_window_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  srw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output srw_pkg::rsp_type rsp_data
);

   logic                req_valid_ff;
   logic                req_valid_in;
   srw_pkg::req_type    req_ff;
   srw_pkg::req_type    req_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   srw_pkg::rsp_type    rsp_ff;
   srw_pkg::rsp_type    rsp_in;
   srw_pkg::window_type win_ff;
   srw_pkg::window_type win_in;
   srw_pkg::window_type win_calc;
   srw_pkg::rsp_type    rsp_calc;
   logic                advance;

   srw_classify u_classify (
      .req      (req_ff),
      .win      (win_ff),
      .win_next (win_calc),
      .rsp      (rsp_calc)
   );

   always_comb begin
      advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready = !req_valid_ff || advance;

      req_valid_in = req_valid_ff;
      req_in       = req_ff;
      if (req_ready) begin
         req_valid_in = req_valid;
         req_in       = req_data;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      win_in       = win_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = rsp_calc;
         win_in       = win_calc;
      end

      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff       <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         win_ff.head_seq    <= '0;
         win_ff.recv_bitmap <= srw_pkg::BITMAP_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         win_ff       <= win_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

endmodule
